/* rtl/core/tfs_pkg.sv */
// Shared types, codes and helpers for the typed field serializer.
package tfs_pkg;

	localparam int unsigned DataW  = 64;
	localparam int unsigned AmtW   = 6;
	localparam int unsigned CntW   = 4;
	localparam logic [7:0]  Low7   = 8'h7f;
	localparam logic [7:0]  Cont   = 8'h80;
	localparam logic [AmtW-1:0] VarShift = AmtW'(7);
	localparam logic [AmtW-1:0] ByteShift = AmtW'(8);

	typedef enum logic [2:0] {
		FN_FIXED8   = 3'd0,
		FN_FIXED16  = 3'd1,
		FN_FIXED32  = 3'd2,
		FN_FIXED64  = 3'd3,
		FN_VAR32    = 3'd4,
		FN_ZZVAR32  = 3'd5,
		FN_VAR64    = 3'd6,
		FN_ZZVAR64  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            left;
		logic [AmtW-1:0] amt;
	} shift_ctl_t;

	// left shift that moves a narrow big-endian field to the top byte lane
	function automatic logic [AmtW-1:0] align_amt(input logic [1:0] size_code);
		logic [AmtW-1:0] a;
		unique case (size_code)
			2'd0:    a = AmtW'(56);
			2'd1:    a = AmtW'(48);
			2'd2:    a = AmtW'(32);
			default: a = AmtW'(0);
		endcase
		return a;
	endfunction

	// index of the final byte of a fixed field
	function automatic logic [CntW-1:0] last_idx(input logic [1:0] size_code);
		logic [CntW-1:0] n;
		unique case (size_code)
			2'd0:    n = CntW'(0);
			2'd1:    n = CntW'(1);
			2'd2:    n = CntW'(3);
			default: n = CntW'(7);
		endcase
		return n;
	endfunction

endpackage

/* rtl/core/tfs_shifter.sv */
// Shared 64-bit shift unit, left or right by a small amount.
module tfs_shifter (
	input  logic [tfs_pkg::DataW-1:0] din,
	input  tfs_pkg::shift_ctl_t       ctl,
	output logic [tfs_pkg::DataW-1:0] dout
);
	import tfs_pkg::*;

	always_comb begin
		if (ctl.left) begin
			dout = din << ctl.amt;
		end else begin
			dout = din >> ctl.amt;
		end
	end

endmodule

/* rtl/core/typed_field_serializer_top.sv */
// Top level of the typed field serializer: sequencer, data register and byte output.
// After acceptance the sequencer enters ST_EMIT, via ST_ALIGN for narrow big-endian fixed fields.
// Throughput: one byte per cycle while the output is not stalled; an item has N bytes (1..10),
//   and 8/16/32-bit big-endian fields add an alignment step; the shared shifter sets the pace.
// The input is stalled from acceptance until the item's last byte enters the output register.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, little_endian cleared.
module typed_field_serializer_top (
	input  logic       clk,
	input  logic       arst_n,
	// item channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] func,
	input  logic [63:0] value,
	// byte channel
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] out_byte,
	output logic       last,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       little_endian
);
	import tfs_pkg::*;

	state_t                state_q, state_d;
	logic [DataW-1:0]      data_q, data_d;
	logic [CntW-1:0]       cnt_q, cnt_d;
	logic [1:0]            size_q, size_d;
	logic                  varint_q, varint_d;
	logic                  le_q;
	logic                  byte_valid_q, byte_valid_d;
	logic [7:0]            out_byte_q, out_byte_d;
	logic                  last_q, last_d;
	shift_ctl_t            sh_ctl;
	logic [DataW-1:0]      sh_out;
	logic                  out_free;
	logic [DataW-1:0]      load_val;
	logic                  is_last;
	logic [7:0]            cur_byte;
	func_t                 fn;

	// Single shift unit: alignment of narrow big-endian fields and every byte step.
	tfs_shifter u_shift (
		.din  (data_q),
		.ctl  (sh_ctl),
		.dout (sh_out)
	);

	assign fn        = func_t'(func);
	assign cfg_ready = 1'b1;

	// Output register frees when empty or when its byte is taken this cycle.
	assign out_free = !byte_valid_q || !byte_stall;

	// Value as loaded: zigzag map and 32-bit masking for the varint forms.
	always_comb begin
		unique case (fn)
			FN_VAR32:   load_val = {32'd0, value[31:0]};
			FN_ZZVAR32: load_val = {32'd0, {value[30:0], 1'b0} ^ {32{value[31]}}};
			FN_ZZVAR64: load_val = {value[62:0], 1'b0} ^ {DataW{value[63]}};
			default:    load_val = value;
		endcase
	end

	// Current byte and end-of-item test. A varint ends when fewer than 8 bits remain,
	// which also caps a 64-bit value at ten bytes.
	always_comb begin
		if (varint_q) begin
			is_last  = (data_q[DataW-1:7] == '0);
			cur_byte = is_last ? data_q[7:0] : ((data_q[7:0] & Low7) | Cont);
		end else begin
			is_last  = (cnt_q == last_idx(size_q));
			cur_byte = le_q ? data_q[7:0] : data_q[DataW-1:DataW-8];
		end
	end

	// Sequencer.
	always_comb begin
		state_d      = state_q;
		data_d       = data_q;
		cnt_d        = cnt_q;
		size_d       = size_q;
		varint_d     = varint_q;
		byte_valid_d = byte_valid_q && byte_stall;
		out_byte_d   = out_byte_q;
		last_d       = last_q;
		sh_ctl.left  = 1'b0;
		sh_ctl.amt   = '0;
		item_stall   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					data_d   = load_val;
					cnt_d    = '0;
					size_d   = func[1:0];
					varint_d = func[2];
					// narrow big-endian fields need their top byte moved to bits 63:56
					if (!func[2] && !le_q && (fn != FN_FIXED64)) begin
						state_d = ST_ALIGN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_ALIGN: begin
				sh_ctl.left = 1'b1;
				sh_ctl.amt  = align_amt(size_q);
				data_d      = sh_out;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				sh_ctl.left = !varint_q && !le_q;
				sh_ctl.amt  = varint_q ? VarShift : ByteShift;
				if (out_free) begin
					byte_valid_d = 1'b1;
					out_byte_d   = cur_byte;
					last_d       = is_last;
					data_d       = sh_out;
					cnt_d        = cnt_q + CntW'(1);
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_valid_q <= 1'b0;
			le_q         <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q      <= state_d;
			byte_valid_q <= byte_valid_d;
			cnt_q        <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				le_q <= little_endian;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		data_q     <= data_d;
		size_q     <= size_d;
		varint_q   <= varint_d;
		out_byte_q <= out_byte_d;
		last_q     <= last_d;
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;

endmodule

/* rtl/core/tfs_checker.sv */
// Port-level checks for the typed field serializer, bound to the top level.
module tfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] out_byte,
	input logic       last
);

	// a stalled byte transaction holds its payload
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(out_byte) && $stable(last))
		else $error("stalled byte changed");

	// an accepted item keeps the input stalled on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after accept");

	// input opens again only once the item's last byte is on the output
	a_release_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_stall) |-> byte_valid && last)
		else $error("input released before last byte");

	// a non-final byte on the output means the item is still in progress
	a_more_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !last |-> item_stall)
		else $error("input released mid item");

endmodule

bind typed_field_serializer_top tfs_checker u_tfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.out_byte   (out_byte),
	.last       (last)
);

/* dv/typed_field_serializer_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for typed_field_serializer_top: directed table, random phases, hold-off.
module typed_field_serializer_top_test;
	import tfs_pkg::*;

	// no-progress limit: well above the receiver hold-off and any random stall streak
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int PRESSURE_ITEMS = 30;
	localparam int DIR_ROWS = 25;

	// one serialized byte as the output channel carries it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} ser_byte_t;

	// directed row: n_bytes == 0 means the expected stream comes from the predictor,
	// otherwise bytes holds the stream typed in, first byte in the top occupied lane
	typedef struct packed {
		func_t       fn;
		logic [63:0] val;
		logic        le;
		logic [3:0]  n_bytes;
		logic [79:0] bytes;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	func_t       item_func = FN_FIXED8;
	logic [63:0] item_value = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_le = 1'b0;

	// predictor's copy of the byte-order register
	logic le_mode = 1'b0;
	// bytes still owed by the block, oldest first
	ser_byte_t pending_bytes[$];
	ser_byte_t want;
	int bad_count = 0;
	int stall_free_cycles = 0;
	// idling percentages of the current phase
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	// set by the stimulus, picked up and cleared by the receiver
	bit hold_req = 1'b0;

	typed_field_serializer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (item_func),
		.value        (item_value),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.little_endian(cfg_le)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Directed table: every format, field extremes, unused high bits, the most negative
	// zigzag inputs, the longest varints and both byte orders.
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{FN_FIXED8,  64'h0,                    1'b0, 4'd1,  80'h00},
		'{FN_FIXED8,  64'hffff_ffff_ffff_ff5a,  1'b0, 4'd1,  80'h5a},
		'{FN_FIXED16, 64'h0000_0000_0000_1234,  1'b0, 4'd2,  80'h1234},
		'{FN_FIXED32, 64'hffff_ffff_0102_0304,  1'b0, 4'd4,  80'h01020304},
		'{FN_FIXED64, 64'h0102_0304_0506_0708,  1'b0, 4'd8,  80'h0102030405060708},
		'{FN_FIXED64, 64'hfedc_ba98_7654_3210,  1'b0, 4'd0,  80'h0},
		'{FN_VAR32,   64'h0,                    1'b0, 4'd1,  80'h00},
		'{FN_VAR32,   64'h7f,                   1'b0, 4'd1,  80'h7f},
		'{FN_VAR32,   64'h80,                   1'b0, 4'd2,  80'h8001},
		'{FN_VAR32,   64'hdead_beef_ffff_ffff,  1'b0, 4'd5,  80'hffffffff0f},
		'{FN_ZZVAR32, 64'hffff_ffff,            1'b0, 4'd1,  80'h01},
		'{FN_ZZVAR32, 64'h1,                    1'b0, 4'd1,  80'h02},
		'{FN_ZZVAR32, 64'h8000_0000,            1'b0, 4'd5,  80'hffffffff0f},
		'{FN_ZZVAR32, 64'h7fff_ffff,            1'b0, 4'd5,  80'hfeffffff0f},
		'{FN_VAR64,   64'h0,                    1'b0, 4'd1,  80'h00},
		'{FN_VAR64,   64'hffff_ffff_ffff_ffff,  1'b0, 4'd10, 80'hffffffffffffffffff01},
		'{FN_ZZVAR64, 64'h8000_0000_0000_0000,  1'b0, 4'd10, 80'hffffffffffffffffff01},
		'{FN_ZZVAR64, 64'hffff_ffff_ffff_ffff,  1'b0, 4'd1,  80'h01},
		'{FN_VAR64,   64'h0123_4567_89ab_cdef,  1'b0, 4'd0,  80'h0},
		'{FN_FIXED8,  64'ha5,                   1'b1, 4'd1,  80'ha5},
		'{FN_FIXED16, 64'h1234,                 1'b1, 4'd2,  80'h3412},
		'{FN_FIXED32, 64'h0102_0304,            1'b1, 4'd4,  80'h04030201},
		'{FN_FIXED64, 64'h0102_0304_0506_0708,  1'b1, 4'd8,  80'h0807060504030201},
		'{FN_VAR64,   64'h80,                   1'b1, 4'd2,  80'h8001},
		'{FN_ZZVAR64, 64'h7fff_ffff_ffff_ffff,  1'b1, 4'd0,  80'h0}
	};

	function automatic void push_byte(input logic [7:0] data, input logic is_last);
		ser_byte_t b;
		b.data = data;
		b.last = is_last;
		pending_bytes = {pending_bytes, b};
	endfunction

	// Predictor: appends the byte stream one item must produce under the current byte order.
	function automatic void encode_field(input func_t fn, input logic [63:0] val);
		int nb;
		int idx;
		int k;
		logic [63:0] u;
		unique case (fn)
			FN_FIXED8, FN_FIXED16, FN_FIXED32, FN_FIXED64: begin
				nb = 1 << int'(fn[1:0]);
				for (k = 0; k < nb; k++) begin
					idx = le_mode ? k : nb - 1 - k;
					push_byte(val[8*idx +: 8], k == nb - 1);
				end
			end
			default: begin
				// varints: narrow to the format width, zigzag-map the signed ones
				unique case (fn)
					FN_VAR32:   u = {32'h0, val[31:0]};
					FN_ZZVAR32: u = {32'h0, {val[30:0], 1'b0} ^ {32{val[31]}}};
					FN_VAR64:   u = val;
					default:    u = {val[62:0], 1'b0} ^ {64{val[63]}};
				endcase
				k = 0;
				// seven bits per byte, low group first, continuation bit on all but the last
				while (u >= 64'h80 && k < 9) begin
					push_byte({1'b1, u[6:0]}, 1'b0);
					u = u >> 7;
					k++;
				end
				push_byte(u[7:0], 1'b1);
			end
		endcase
	endfunction

	// Offer one item and hold it until the block takes it. A random gap goes first
	// when the phase idles the sender; valid drops only when a gap really follows.
	task automatic send_item(input func_t fn, input logic [63:0] val,
			input logic [3:0] n_typed, input logic [79:0] typed);
		int k;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		item_valid <= 1'b1;
		item_func <= fn;
		item_value <= val;
		do @(posedge clk); while (item_stall);
		// transaction accepted at this edge: record the stream it owes
		if (n_typed == 0)
			encode_field(fn, val);
		else
			for (k = 0; k < n_typed; k++)
				push_byte(typed[8*(n_typed-1-k) +: 8], k == n_typed - 1);
	endtask

	// Stop offering items and wait until every owed byte has come out.
	task automatic drain_bytes();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	// Byte-order register write; only issued while the block is drained.
	task automatic write_le(input logic le);
		cfg_valid <= 1'b1;
		cfg_le <= le;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		le_mode = le;
	endtask

	// Receiver: random stall per the phase; on request, one long hold-off counted here
	// so the block backs up and stalls its item input.
	initial begin : byte_sink
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				byte_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			byte_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Output check: each byte transaction against the oldest owed byte.
	always @(posedge clk) begin
		if (arst_n && byte_valid === 1'b1 && !byte_stall) begin
			if (pending_bytes.size() == 0) begin
				if (bad_count < 10)
					$display("%0t: unexpected byte %02h last %0b", $time, out_byte, last);
				bad_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.data || last !== want.last) begin
					if (bad_count < 10)
						$display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
							$time, want.data, out_byte, want.last, last);
					bad_count++;
				end
			end
		end
	end

	// Watchdog: any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (byte_valid === 1'b1 && !byte_stall)
					|| (cfg_valid && cfg_ready))
				stall_free_cycles <= 0;
			else
				stall_free_cycles <= stall_free_cycles + 1;
			if (stall_free_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		int p;
		int n;
		int r;
		func_t fn;
		logic [63:0] v;
		int phase_tx [4];
		int phase_rx [4];
		logic phase_le [4];

		phase_tx = '{0, 76, 0, 15};
		phase_rx = '{0, 0, 76, 15};
		phase_le = '{1'b1, 1'b0, 1'b1, 1'b0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the byte order changes only between drained groups
		write_le(1'b0);
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].le != le_mode) begin
				drain_bytes();
				write_le(dir_rows[i].le);
			end
			send_item(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].n_bytes,
				dir_rows[i].bytes);
		end

		// random phases, one idling pattern and byte order each
		for (p = 0; p < 4; p++) begin
			drain_bytes();
			tx_idle_pct = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			write_le(phase_le[p]);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				fn = func_t'($urandom_range(7));
				v = {$urandom, $urandom};
				r = $urandom_range(9);
				// mostly short magnitudes so every varint length shows up
				if (r < 5)
					v = v >> $urandom_range(63);
				else if (r == 5)
					v = ~(v >> $urandom_range(63));
				else if (r == 6)
					case ($urandom_range(3))
						0: v = '0;
						1: v = '1;
						2: v = 64'h8000_0000_0000_0000;
						default: v = 64'h0000_0000_8000_0000;
					endcase
				send_item(fn, v, 4'd0, 80'h0);
			end
		end

		// back-pressure: receiver holds off while items keep coming back to back
		drain_bytes();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 1'b1;
		for (n = 0; n < PRESSURE_ITEMS; n++) begin
			fn = func_t'($urandom_range(7));
			send_item(fn, {$urandom, $urandom} >> $urandom_range(63), 4'd0, 80'h0);
		end

		drain_bytes();
		// trailing quiet time catches any stray extra byte
		repeat (20) @(posedge clk);
		if (bad_count == 0 && pending_bytes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
